FILE: rtl/chte_pkg.sv
// Shared types and constants of the chained hash table engine.
// No dependencies; chte_mod and the top level use it through scoped names.
package chte_pkg;

  localparam int MaxBucketsDefault  = 64;
  localparam int PoolEntriesDefault = 256;

  // Widths fixed by the item format
  localparam int KeyW  = 14;
  localparam int NumW  = 14;
  localparam int DescW = 64;
  localparam int SizeW = 7;
  localparam int HashW = 14;  // 260*31 + 10*31 + 15 fits in 14 bits

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef struct packed {
    logic             mode;
    logic [4:0]       key_first_letter;
    logic [4:0]       key_second_letter;
    logic [3:0]       key_digit;
    logic [NumW-1:0]  item_number;
    logic [DescW-1:0] item_description;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [5:0]       bucket_index;
    logic [NumW-1:0]  found_number;
    logic [DescW-1:0] found_description;
  } rsp_t;

  // Handshake between the sequencer and the modulo unit
  typedef struct packed {
    logic             start;
    logic [HashW-1:0] dividend;
  } mod_req_t;

endpackage

FILE: rtl/chte_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module chte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/chte_mod.sv
// Restoring remainder unit: hash value mod table size, one dividend bit a cycle.
// Depends on chte_pkg.
module chte_mod #(
  parameter int MAX_BUCKETS = chte_pkg::MaxBucketsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  chte_pkg::mod_req_t                req,
  input  logic [$clog2(MAX_BUCKETS):0]      size,
  output logic                              done,
  output logic [$clog2(MAX_BUCKETS)-1:0]    rem
);

  localparam int BktW = $clog2(MAX_BUCKETS);
  localparam int CntW = $clog2(chte_pkg::HashW);

  logic [chte_pkg::HashW-1:0] dvd;
  logic [CntW-1:0]            cnt;
  logic                       busy;
  logic [BktW:0]              shifted;
  logic [BktW-1:0]            rem_next;

  // One restoring step
  always_comb begin
    shifted = {rem, dvd[chte_pkg::HashW-1]};
    if (shifted >= size) begin
      rem_next = BktW'(shifted - size);
    end else begin
      rem_next = BktW'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd  <= req.dividend;
        rem  <= '0;
        cnt  <= CntW'(chte_pkg::HashW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        dvd <= dvd << 1;
        rem <= rem_next;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/chained_hash_table_engine_top.sv
// Top level of the chained hash table engine: sequencer, head and slot memories.
// Depends on chte_pkg, chte_ram and chte_mod.
//
// One operation at a time. An item goes through the modulo unit (one hash bit a
// cycle), the bucket head read, one slot memory read per chain entry visited,
// and a finishing state. The result sits in an output register, so the next
// item can be taken while it waits. Bucket heads carry flip-flop valid bits
// cleared by reset, so no clearing pass is needed; pool slots are handed out
// in order.
module chained_hash_table_engine_top #(
  parameter int MAX_BUCKETS  = chte_pkg::MaxBucketsDefault,
  parameter int POOL_ENTRIES = chte_pkg::PoolEntriesDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  chte_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output chte_pkg::rsp_t             rsp,
  input  logic                       cfg_we,
  input  logic [chte_pkg::SizeW-1:0] cfg_data
);

  localparam int BktW   = $clog2(MAX_BUCKETS);
  localparam int PtrW   = $clog2(POOL_ENTRIES);
  localparam int CntW   = $clog2(POOL_ENTRIES + 1);
  localparam int KeyW   = chte_pkg::KeyW;
  localparam int NumW   = chte_pkg::NumW;
  localparam int DescW  = chte_pkg::DescW;
  // Slot word: {key, number, description, next_live, next}
  localparam int SlotW  = KeyW + NumW + DescW + 1 + PtrW;
  localparam int NextLo = 0;
  localparam int LiveB  = PtrW;
  localparam int DescLo = PtrW + 1;
  localparam int NumLo  = DescLo + DescW;
  localparam int KeyLo  = NumLo + NumW;

  typedef enum logic [2:0] {S_IDLE, S_HASH, S_HEAD, S_WALK, S_DONE} state_t;

  state_t                     state;
  logic [chte_pkg::SizeW-1:0] table_size;
  logic [BktW:0]              size_eff;
  logic                       op;
  logic [KeyW-1:0]            key;
  logic [NumW-1:0]            number;
  logic [DescW-1:0]           desc;
  logic [BktW-1:0]            bucket;
  logic                       hit;
  logic [NumW-1:0]            hit_num;
  logic [DescW-1:0]           hit_desc;
  logic [PtrW-1:0]            head_ptr;
  logic                       head_live;
  logic [MAX_BUCKETS-1:0]     head_vld;
  logic [CntW-1:0]            slots_used;

  chte_pkg::mod_req_t         mod_req;
  logic                       mod_done;
  logic [BktW-1:0]            mod_rem;

  logic                       head_re;
  logic [PtrW-1:0]            head_rdata;
  logic                       slot_re;
  logic [PtrW-1:0]            slot_raddr;
  logic [SlotW-1:0]           slot_rdata;
  logic                       head_we;
  logic                       slot_we;
  logic [SlotW-1:0]           slot_wdata;

  logic                       req_xfer;
  logic                       finish;
  logic                       full;
  logic                       ins_ok;
  chte_pkg::status_t          status_next;

  assign req_ready = (state == S_IDLE);
  assign req_xfer  = req_valid && req_ready;
  assign finish    = (state == S_DONE) && (!rsp_valid || rsp_ready);
  assign full      = (slots_used == CntW'(POOL_ENTRIES));
  assign ins_ok    = (op == chte_pkg::OP_INSERT) && !hit && !full;

  // Effective bucket count: zero means one, saturate at MAX_BUCKETS
  always_comb begin
    if (table_size == '0) begin
      size_eff = (BktW + 1)'(1);
    end else if (32'(table_size) > MAX_BUCKETS) begin
      size_eff = (BktW + 1)'(MAX_BUCKETS);
    end else begin
      size_eff = (BktW + 1)'(table_size);
    end
  end

  // Hash value and modulo start
  always_comb begin
    mod_req.start    = req_xfer;
    mod_req.dividend = chte_pkg::HashW'(260 * 32'(req.key_first_letter)
                       + 10 * 32'(req.key_second_letter) + 32'(req.key_digit));
  end

  chte_mod #(.MAX_BUCKETS(MAX_BUCKETS)) u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mod_req),
    .size (size_eff),
    .done (mod_done),
    .rem  (mod_rem)
  );

  // Memory port control
  assign head_re = (state == S_HASH) && mod_done;
  assign head_we = finish && ins_ok;
  assign slot_we = finish && ins_ok;
  assign slot_wdata = {key, number, desc, head_live, head_ptr};

  always_comb begin
    slot_re    = 1'b0;
    slot_raddr = head_rdata;
    if (state == S_HEAD) begin
      slot_re = head_vld[bucket];
    end else if (state == S_WALK) begin
      slot_raddr = slot_rdata[NextLo +: PtrW];
      slot_re    = (slot_rdata[KeyLo +: KeyW] != key) && slot_rdata[LiveB];
    end
  end

  chte_ram #(.WIDTH(PtrW), .DEPTH(MAX_BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (bucket),
    .wdata (slots_used[PtrW-1:0]),
    .re    (head_re),
    .raddr (mod_rem),
    .rdata (head_rdata)
  );

  chte_ram #(.WIDTH(SlotW), .DEPTH(POOL_ENTRIES)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slots_used[PtrW-1:0]),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Result status
  always_comb begin
    if (op == chte_pkg::OP_INSERT) begin
      if (hit) begin
        status_next = chte_pkg::ST_DUPLICATE;
      end else if (full) begin
        status_next = chte_pkg::ST_FULL;
      end else begin
        status_next = chte_pkg::ST_INSERTED;
      end
    end else begin
      status_next = hit ? chte_pkg::ST_FOUND : chte_pkg::ST_NOT_FOUND;
    end
  end

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      table_size <= chte_pkg::SizeW'(31);
      head_vld   <= '0;
      slots_used <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_size <= cfg_data;
      end
      // A new result replaces the one leaving in the same cycle
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_xfer) begin
            op     <= req.mode;
            key    <= {req.key_first_letter, req.key_second_letter, req.key_digit};
            number <= req.item_number;
            desc   <= req.item_description;
            state  <= S_HASH;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            bucket <= mod_rem;
            state  <= S_HEAD;
          end
        end
        S_HEAD: begin
          head_ptr  <= head_rdata;
          head_live <= head_vld[bucket];
          hit       <= 1'b0;
          state     <= head_vld[bucket] ? S_WALK : S_DONE;
        end
        S_WALK: begin
          // Compare the slot just read; follow the link on a miss
          if (slot_rdata[KeyLo +: KeyW] == key) begin
            hit      <= 1'b1;
            hit_num  <= slot_rdata[NumLo +: NumW];
            hit_desc <= slot_rdata[DescLo +: DescW];
            state    <= S_DONE;
          end else if (!slot_rdata[LiveB]) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (finish) begin
            if (ins_ok) begin
              head_vld[bucket] <= 1'b1;
              slots_used       <= slots_used + 1'b1;
            end
            rsp.status                <= status_next;
            rsp.bucket_index          <= 6'(bucket);
            rsp.found_number          <= (status_next == chte_pkg::ST_FOUND) ? hit_num : '0;
            rsp.found_description     <= (status_next == chte_pkg::ST_FOUND) ? hit_desc : '0;
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= CntW'(POOL_ENTRIES))
    else $error("slot count beyond pool size");

  a_alloc_step: assert property (@(posedge clk) disable iff (rst)
    finish && ins_ok |=> slots_used == $past(slots_used) + 1'b1)
    else $error("insert did not allocate one slot");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != chte_pkg::ST_FOUND |->
      rsp.found_number == '0 && rsp.found_description == '0)
    else $error("found fields set without a hit");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> state == S_HASH && !req_ready)
    else $error("second item taken while busy");

endmodule

FILE: bench/chained_hash_table_engine_checker.sv
// Checker for the chained hash table engine: watches the request and response
// channels, predicts each response from its own table copy, and compares.
// Depends on chte_pkg.
module chained_hash_table_engine_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_ready,
  input  chte_pkg::req_t             req,
  input  logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  chte_pkg::rsp_t             rsp,
  input  logic                       cfg_we,
  input  logic [chte_pkg::SizeW-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Buckets = chte_pkg::MaxBucketsDefault;
  localparam int Pool    = chte_pkg::PoolEntriesDefault;

  // model copy of the table
  logic [chte_pkg::SizeW-1:0] size_reg;
  logic [8:0]                 head_ptr  [Buckets];
  logic                       head_live [Buckets];
  logic [chte_pkg::KeyW-1:0]  key_mem   [Pool];
  logic [chte_pkg::NumW-1:0]  num_mem   [Pool];
  logic [chte_pkg::DescW-1:0] desc_mem  [Pool];
  logic [8:0]                 next_ptr  [Pool];
  logic                       next_live [Pool];
  int                         used;
  chte_pkg::rsp_t             expected_rsp [$];

  // predict the response to one request, updating the table copy
  function automatic chte_pkg::rsp_t lookup_or_insert(chte_pkg::req_t r);
    chte_pkg::rsp_t o;
    int unsigned n, sz, bkt, cur, steps;
    logic [chte_pkg::KeyW-1:0] key;
    logic live, hit;
    int slot;
    n = 260 * r.key_first_letter + 10 * r.key_second_letter + r.key_digit;
    sz = size_reg;
    if (sz == 0) sz = 1;
    if (sz > Buckets) sz = Buckets;
    bkt = n % sz;
    key = {r.key_first_letter, r.key_second_letter, r.key_digit};
    hit = 0;
    slot = 0;
    live = head_live[bkt];
    cur = head_ptr[bkt];
    for (steps = 0; live && steps < used && !hit; steps++) begin
      if (key_mem[cur] == key) begin
        hit = 1;
        slot = cur;
      end else begin
        live = next_live[cur];
        cur = next_ptr[cur];
      end
    end
    o = '0;
    o.bucket_index = bkt[5:0];
    if (r.mode == chte_pkg::OP_INSERT) begin
      if (hit) begin
        o.status = chte_pkg::ST_DUPLICATE;
      end else if (used >= Pool) begin
        o.status = chte_pkg::ST_FULL;
      end else begin
        key_mem[used] = key;
        num_mem[used] = r.item_number;
        desc_mem[used] = r.item_description;
        next_ptr[used] = head_ptr[bkt];
        next_live[used] = head_live[bkt];
        head_ptr[bkt] = used[8:0];
        head_live[bkt] = 1'b1;
        used++;
        o.status = chte_pkg::ST_INSERTED;
      end
    end else if (hit) begin
      o.status = chte_pkg::ST_FOUND;
      o.found_number = num_mem[slot];
      o.found_description = desc_mem[slot];
    end else begin
      o.status = chte_pkg::ST_NOT_FOUND;
    end
    return o;
  endfunction

  assign pending = expected_rsp.size();

  always @(posedge clk) begin
    chte_pkg::rsp_t e;
    if (rst) begin
      size_reg <= 7'd31;
      for (int i = 0; i < Buckets; i++) head_live[i] = 1'b0;
      used = 0;
      expected_rsp.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) size_reg <= cfg_data;
      if (req_valid && req_ready)
        expected_rsp.insert(expected_rsp.size(), lookup_or_insert(req));
      // compare each response transfer with the oldest prediction
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          if (fail_count < 10) $display("unexpected response %p", rsp);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_rsp.pop_front();
          if (rsp.status !== e.status || rsp.bucket_index !== e.bucket_index ||
              rsp.found_number !== e.found_number ||
              rsp.found_description !== e.found_description) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", e, rsp);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: bench/chained_hash_table_engine_top_test.sv
// Stimulus and verdict for the chained hash table engine.
// Depends on chte_pkg, the engine RTL and chained_hash_table_engine_checker.
module chained_hash_table_engine_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic req_valid, req_ready, rsp_valid, rsp_ready, cfg_we;
  chte_pkg::req_t req;
  chte_pkg::rsp_t rsp;
  logic [chte_pkg::SizeW-1:0] cfg_data;
  int fail_count, pending;
  int send_idle_pct, recv_idle_pct;
  int cycles;
  logic [chte_pkg::KeyW-1:0] known_keys [$];

  chained_hash_table_engine_top uut (.*);

  chained_hash_table_engine_checker check (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one request transfer; valid stays up into the next item unless the sender idles
  task automatic send_req(logic m, logic [4:0] a, logic [4:0] b, logic [3:0] d,
                          logic [13:0] num, logic [63:0] desc);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= {m, a, b, d, num, desc};
    known_keys.insert(known_keys.size(), {a, b, d});
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic send_random(bit wild);
    logic [chte_pkg::KeyW-1:0] k;
    logic [4:0] a, b;
    logic [3:0] d;
    if (!wild && known_keys.size() > 0 && $urandom_range(1)) begin
      k = known_keys[$urandom_range(known_keys.size() - 1)];
      {a, b, d} = k;
    end else if (wild) begin
      a = 5'($urandom); b = 5'($urandom); d = 4'($urandom);
    end else begin
      a = 5'($urandom_range(25)); b = 5'($urandom_range(25)); d = 4'($urandom_range(9));
    end
    send_req(1'($urandom), a, b, d, wild ? 14'($urandom) : 14'($urandom_range(9999)),
             {$urandom, $urandom});
  endtask

  // write the size register while idle
  task automatic set_size(logic [chte_pkg::SizeW-1:0] v);
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [chte_pkg::SizeW-1:0] sizes [6];
    sizes = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd7, 7'd31};
    rst = 1; req_valid = 0; cfg_we = 0; cfg_data = '0; req = '0;
    send_idle_pct = 17; recv_idle_pct = 58;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, both operations, duplicate, miss, odd characters
    send_req(chte_pkg::OP_SEARCH, 0, 0, 0, 0, 0);
    send_req(chte_pkg::OP_INSERT, 0, 0, 0, 0, '0);
    send_req(chte_pkg::OP_INSERT, 25, 25, 9, 9999, '1);
    send_req(chte_pkg::OP_INSERT, 0, 0, 0, 5, 64'h55);
    send_req(chte_pkg::OP_SEARCH, 25, 25, 9, 0, 0);
    send_req(chte_pkg::OP_SEARCH, 0, 0, 0, 0, 0);
    send_req(chte_pkg::OP_INSERT, 31, 31, 15, 14'h3fff, 64'hdead_beef_0123_4567);
    send_req(chte_pkg::OP_SEARCH, 31, 31, 15, 0, '1);
    send_req(chte_pkg::OP_SEARCH, 0, 1, 0, 0, 0);
    send_req(chte_pkg::OP_INSERT, 0, 3, 1, 7, 64'h1);  // same bucket as AA0 at size 31
    send_req(chte_pkg::OP_SEARCH, 0, 3, 1, 0, 0);
    // random phases across sizes and idling patterns
    for (int p = 0; p < 6; p++) begin
      set_size(sizes[p]);
      if (p == 2) begin send_idle_pct = 58; recv_idle_pct = 17; end
      if (p == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int i = 0; i < 290; i++) send_random($urandom_range(9) == 0);
    end
    // pool is full by now; hit full and duplicate paths
    send_req(chte_pkg::OP_INSERT, 1, 2, 3, 1, 1);
    send_req(chte_pkg::OP_INSERT, 0, 0, 0, 1, 1);
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
